@@ design/envelope_soft_knee_compressor_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the soft-knee compressor
// Shared macros that the checker uses to write its concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_SOFT_KNEE_COMPRESSOR_TOP_DEFINES_SVH
`define ENVELOPE_SOFT_KNEE_COMPRESSOR_TOP_DEFINES_SVH

// Property checked on every rising edge once reset has been released.
`define ESKC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ESKC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/eskc_pkg.sv @@
// ----------------------------------------------------------------------------
// Soft-knee compressor package
// Formats, register indexes and reset values shared by the compressor files.
// ----------------------------------------------------------------------------
package eskc_pkg;

    // Default sample width; samples are signed Q3.(SAMPLE_BITS-4).
    localparam int SAMPLE_BITS_DEF = 24;

    // Register formats.
    localparam int COEF_BITS  = 24;
    localparam int DEPTH_BITS = 17;

    // Configuration port.
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_ADDR_BITS-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RELEASE = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DEPTH   = 2'd2;

    localparam logic [COEF_BITS-1:0]  ATTACK_RESET  = 24'd16690059;
    localparam logic [COEF_BITS-1:0]  RELEASE_RESET = 24'd16774303;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET   = 17'd0;

    // Gain is Q0.24 and may reach exactly one, so it needs 25 bits.
    localparam int GAIN_BITS = 25;

    // Width of the mul_a operand of the shared multiplier.
    localparam int MUL_A_BITS = 25;

    // Make-up factor, Q1.18.
    localparam int MAKEUP_FRAC = 18;

    // The gain quotient is produced one bit per step.
    localparam int DIV_STEPS = 25;

endpackage

@@ design/envelope_soft_knee_compressor_top.sv @@
// ----------------------------------------------------------------------------
// Soft-knee compressor with peak envelope follower
// Usage:
//   Samples arrive on the s_axis channel, one signed sample per item, and
//   compressed samples leave on the m_axis channel in the same order, one per
//   input item. Registers are written through cfg_we/cfg_addr/cfg_wdata: index
//   0 is the attack coefficient, 1 the release coefficient and 2 the
//   compression depth; other indexes are ignored. The user must write them
//   only while the block is idle; the block itself does not enforce this.
//   One shared multiplier and a one-bit-per-cycle restoring divider are run
//   by a small sequencer, so the block takes one item at a time.
//   An item whose envelope is above the threshold also runs the 25-step gain
//   division before its result appears. s_axis_tready returns in the same
//   cycle as the result appears, so the next item is accepted only after the
//   previous one has left the sequencer.
//   A finished result waits in the output register; the next item may be
//   accepted and worked on meanwhile, and only its own result waits for the
//   receiver to take the previous one.
//   Reset clears the envelope, restores the register defaults and empties
//   the output register.
// ----------------------------------------------------------------------------
module envelope_soft_knee_compressor_top
    import eskc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]             cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]             cfg_wdata,
    // Input samples.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample_in
    // Output samples.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata   // sample_out
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAC_BITS  = SAMPLE_BITS - 4;
    localparam int PROD_BITS  = SAMPLE_BITS + MUL_A_BITS;
    localparam int DEN_BITS   = SAMPLE_BITS + 19;
    localparam int REM_BITS   = DEN_BITS + 1;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);
    localparam int U_BITS     = PROD_BITS - MAKEUP_FRAC;

    localparam logic [SAMPLE_BITS-1:0] THRESH  = SAMPLE_BITS'(1) << (FRAC_BITS - 2);
    localparam logic [DEN_BITS-1:0]    DIV_ONE = DEN_BITS'(1) << (FRAC_BITS + 16);
    localparam logic [GAIN_BITS-1:0]   UNITY   = GAIN_BITS'(1) << COEF_BITS;
    localparam logic [PROD_BITS-1:0]   HALF_24 = PROD_BITS'(1) << (COEF_BITS - 1);
    localparam logic [PROD_BITS-1:0]   HALF_MK = PROD_BITS'(1) << (MAKEUP_FRAC - 1);
    localparam logic [U_BITS-1:0]      POS_LIM = U_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic [U_BITS-1:0]      NEG_LIM = U_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [CNT_BITS-1:0]    LAST_STEP = CNT_BITS'(DIV_STEPS - 1);

    typedef enum logic [12:0] {
        ST_IDLE       = 13'b0000000000001,
        ST_SEL        = 13'b0000000000010,
        ST_MUL_OLD    = 13'b0000000000100,
        ST_MUL_NEW    = 13'b0000000001000,
        ST_ENV        = 13'b0000000010000,
        ST_OVER       = 13'b0000000100000,
        ST_MUL_OVER   = 13'b0000001000000,
        ST_DEN        = 13'b0000010000000,
        ST_DIV        = 13'b0000100000000,
        ST_MUL_GAIN   = 13'b0001000000000,
        ST_SCALE      = 13'b0010000000000,
        ST_MUL_MAKEUP = 13'b0100000000000,
        ST_OUT        = 13'b1000000000000
    } state_t;

    // Control state.
    state_t                 state_reg, state_next;
    logic [COEF_BITS-1:0]   att_reg;
    logic [COEF_BITS-1:0]   rel_reg;
    logic [DEPTH_BITS-1:0]  depth_reg;
    logic [SAMPLE_BITS-1:0] env_reg, env_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;

    // Datapath registers.
    logic                   neg_reg, neg_next;
    logic [SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic [MUL_A_BITS-1:0]  coef_reg, coef_next;
    logic [PROD_BITS-1:0]   prod_reg, prod_next;
    logic [PROD_BITS-1:0]   acc_reg, acc_next;
    logic [SAMPLE_BITS-1:0] over_reg, over_next;
    logic [DEN_BITS-1:0]    den_reg, den_next;
    logic [REM_BITS-1:0]    rem_reg, rem_next;
    logic [GAIN_BITS-1:0]   gain_reg, gain_next;
    logic [SAMPLE_BITS-1:0] t_reg, t_next;
    logic [SAMPLE_BITS-1:0] out_data_reg, out_data_next;

    // Shared multiplier operands and intermediate values.
    logic [MUL_A_BITS-1:0]  mul_a;
    logic [SAMPLE_BITS-1:0] mul_b;
    logic [SAMPLE_BITS-1:0] raw;
    logic [PROD_BITS-1:0]   sum;
    logic [REM_BITS-1:0]    diff;
    logic                   ge;
    logic [U_BITS-1:0]      u_val;
    logic [U_BITS-1:0]      u_sat;

    assign raw           = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_BITS'(out_data_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_OLD:
            begin
                mul_a = coef_reg;
                mul_b = env_reg;
            end
            ST_MUL_NEW:
            begin
                mul_a = coef_reg;
                mul_b = mag_reg;
            end
            ST_MUL_OVER:
            begin
                mul_a = MUL_A_BITS'(depth_reg);
                mul_b = over_reg;
            end
            ST_MUL_GAIN:
            begin
                mul_a = gain_reg;
                mul_b = mag_reg;
            end
            ST_MUL_MAKEUP:
            begin
                mul_a = coef_reg;
                mul_b = t_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared adder path: envelope sum, rounding of the gain and make-up products.
    always_comb
    begin
        unique case (state_reg)
            ST_ENV:   sum = acc_reg + prod_reg;
            ST_SCALE: sum = prod_reg + HALF_24;
            default:  sum = prod_reg + HALF_MK;
        endcase
    end

    // One restoring step of the gain division.
    assign ge   = (rem_reg >= {1'b0, den_reg});
    assign diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    // Make-up result and saturation against the signed range.
    assign u_val = sum[PROD_BITS-1:MAKEUP_FRAC];
    always_comb
    begin
        if (neg_reg)
        begin
            u_sat = (u_val > NEG_LIM) ? NEG_LIM : u_val;
        end
        else
        begin
            u_sat = (u_val > POS_LIM) ? POS_LIM : u_val;
        end
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        env_next       = env_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        coef_next      = coef_reg;
        prod_next      = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
        acc_next       = acc_reg;
        over_next      = over_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        gain_next      = gain_reg;
        t_next         = t_reg;
        out_data_next  = out_data_reg;

        // The receiver takes the waiting result.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    neg_next   = raw[SAMPLE_BITS-1];
                    mag_next   = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                // Attack when the magnitude rises above the envelope.
                coef_next  = {1'b0, (mag_reg > env_reg) ? att_reg : rel_reg};
                state_next = ST_MUL_OLD;
            end
            ST_MUL_OLD:
            begin
                coef_next  = UNITY - coef_reg;
                state_next = ST_MUL_NEW;
            end
            ST_MUL_NEW:
            begin
                acc_next   = prod_reg + HALF_24;
                state_next = ST_ENV;
            end
            ST_ENV:
            begin
                env_next   = sum[COEF_BITS +: SAMPLE_BITS];
                state_next = ST_OVER;
            end
            ST_OVER:
            begin
                if (env_reg > THRESH)
                begin
                    over_next  = env_reg - THRESH;
                    state_next = ST_MUL_OVER;
                end
                else
                begin
                    gain_next  = UNITY;
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_OVER:
            begin
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                den_next   = DIV_ONE + DEN_BITS'({prod_reg[SAMPLE_BITS+15:0], 2'b00});
                rem_next   = REM_BITS'(DIV_ONE);
                gain_next  = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = {diff[REM_BITS-2:0], 1'b0};
                gain_next = {gain_reg[GAIN_BITS-2:0], ge};
                cnt_next  = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                t_next     = sum[COEF_BITS +: SAMPLE_BITS];
                coef_next  = (MUL_A_BITS'(1) << MAKEUP_FRAC) + MUL_A_BITS'(depth_reg);
                state_next = ST_MUL_MAKEUP;
            end
            ST_MUL_MAKEUP:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // The make-up product is held while the result waits.
                prod_next = prod_reg;
                // Wait until the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = neg_reg ? (~u_sat[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                                             : u_sat[SAMPLE_BITS-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and the configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            env_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            att_reg       <= ATTACK_RESET;
            rel_reg       <= RELEASE_RESET;
            depth_reg     <= DEPTH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            env_reg       <= env_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_ATTACK:  att_reg   <= cfg_wdata[COEF_BITS-1:0];
                    REG_RELEASE: rel_reg   <= cfg_wdata[COEF_BITS-1:0];
                    REG_DEPTH:   depth_reg <= cfg_wdata[DEPTH_BITS-1:0];
                    default:     ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        coef_reg     <= coef_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        over_reg     <= over_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        gain_reg     <= gain_next;
        t_reg        <= t_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ design/eskc_checker.sv @@
// ----------------------------------------------------------------------------
// Soft-knee compressor port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "envelope_soft_knee_compressor_top_defines.svh"

module eskc_port_checker
#(
    parameter int SAMPLE_BITS = 24
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata   // sample_out
);

    // An edge seen in reset leaves the output register empty at the next edge.
    `ESKC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_axis_tvalid, "output valid after reset")

    // An accepted item occupies the sequencer, so input is refused next cycle.
    `ESKC_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
                 "input ready straight after an accepted item")

    // A fresh result appears exactly as the sequencer returns to idle.
    `ESKC_ASSERT(a_result_frees_input, $rose(m_axis_tvalid) |-> s_axis_tready,
                 "result appeared while the sequencer was still busy")

    // A stalled result holds its value.
    `ESKC_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=>
                 m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind envelope_soft_knee_compressor_top eskc_port_checker #(.SAMPLE_BITS(SAMPLE_BITS))
    u_eskc_port_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/eskc_checker.sv @@
// ----------------------------------------------------------------------------
// Soft-knee compressor result checker
// Watches the register port and both sample channels. A private copy of the
// registers and the envelope predicts each compressed sample when its input
// item is accepted, and every output item is compared with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module eskc_checker
    import eskc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [SAMPLE_BITS_DEF-1:0] s_tdata,   // sample_in
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [SAMPLE_BITS_DEF-1:0] m_tdata,   // sample_out
    output int                       fail_count,
    output int                       pending,
    output int                       samples_in,
    output int                       samples_out,
    output int                       knee_hits,
    output int                       clip_hits
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB   = SAMPLE_BITS_DEF;
    localparam int FRAC = SB - 4;

    localparam logic [63:0] COEF_ONE  = 64'd1 << COEF_BITS;
    localparam logic [63:0] THRESH    = 64'd1 << (FRAC - 2);
    localparam logic [63:0] DIV_ONE   = 64'd1 << (FRAC + 16);
    localparam logic [63:0] GAIN_NUM  = DIV_ONE << COEF_BITS;
    localparam logic [63:0] POS_LIMIT = (64'd1 << (SB - 1)) - 64'd1;
    localparam logic [63:0] NEG_LIMIT = 64'd1 << (SB - 1);

    // Shadow registers and envelope, kept in step with the block.
    logic [COEF_BITS-1:0]  attack_q  = ATTACK_RESET;
    logic [COEF_BITS-1:0]  release_q = RELEASE_RESET;
    logic [DEPTH_BITS-1:0] depth_q   = DEPTH_RESET;
    logic [31:0]           env_q     = '0;

    logic [SB-1:0] expected_out[$];
    int errors   = 0;
    int n_in     = 0;
    int n_out    = 0;
    int n_knee   = 0;
    int n_clip   = 0;

    task automatic report_mismatch(input string msg);
        if (errors < 20)
        begin
            $display("eskc_checker: %0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    // Works out the compressed sample for one input and advances the envelope.
    function automatic logic [SB-1:0] compress_sample(input logic [SB-1:0] x);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] c;
        logic [63:0] env;
        logic [63:0] g;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] lim;
        neg = x[SB-1];
        // The most negative sample has an exact magnitude of full scale.
        mag = neg ? ((64'd1 << SB) - 64'(x)) : 64'(x);

        // One-pole peak follower: attack while rising, release otherwise.
        c   = (mag > 64'(env_q)) ? 64'(attack_q) : 64'(release_q);
        env = (c * 64'(env_q) + (COEF_ONE - c) * mag + (COEF_ONE >> 1)) >> COEF_BITS;
        env_q = env[31:0];

        // Gain reduction only above the knee; the divide is exact floor.
        if (env > THRESH)
        begin
            g = GAIN_NUM / (DIV_ONE + 64'd4 * 64'(depth_q) * (env - THRESH));
            n_knee++;
        end
        else
        begin
            g = COEF_ONE;
        end

        // Apply the gain and make-up to the magnitude, rounding half up.
        t = (mag * g + (COEF_ONE >> 1)) >> COEF_BITS;
        u = (t * ((64'd1 << MAKEUP_FRAC) + 64'(depth_q)) + (64'd1 << (MAKEUP_FRAC - 1)))
            >> MAKEUP_FRAC;

        lim = neg ? NEG_LIMIT : POS_LIMIT;
        if (u > lim)
        begin
            u = lim;
            n_clip++;
        end
        u = neg ? (64'd0 - u) : u;
        return u[SB-1:0];
    endfunction

    // Everything is sampled at the rising edge, before the drivers update.
    always @(posedge clk or negedge rst_n)
    begin
        logic [SB-1:0] want;
        if (!rst_n)
        begin
            attack_q  = ATTACK_RESET;
            release_q = RELEASE_RESET;
            depth_q   = DEPTH_RESET;
            env_q     = '0;
            expected_out.delete();
        end
        else
        begin
            // Register writes; unknown indexes fall through untouched.
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_ATTACK:  attack_q  = cfg_wdata[COEF_BITS-1:0];
                    REG_RELEASE: release_q = cfg_wdata[COEF_BITS-1:0];
                    REG_DEPTH:   depth_q   = cfg_wdata[DEPTH_BITS-1:0];
                    default:     ;
                endcase
            end

            // Results are retired before new predictions are queued.
            if (m_tvalid && m_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    report_mismatch($sformatf("sample_out %0d arrived with no item waiting",
                                              $signed(m_tdata)));
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (m_tdata !== want)
                    begin
                        report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                                  n_out, $signed(m_tdata), $signed(want)));
                    end
                end
                n_out++;
            end

            if (s_tvalid && s_tready)
            begin
                expected_out.push_back(compress_sample(s_tdata));
                n_in++;
            end
        end

        fail_count  <= errors;
        pending     <= expected_out.size();
        samples_in  <= n_in;
        samples_out <= n_out;
        knee_hits   <= n_knee;
        clip_hits   <= n_clip;
    end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Soft-knee compressor testbench
// Drives audio samples through the compressor under a series of register
// settings, from a short directed set of edge cases to long random bursts
// of silence, quiet, near-knee and loud material. Both channels idle at
// random, and the output side holds off once for a long stretch so that the
// block backs up. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    import eskc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int DW = ((SB + 7) / 8) * 8;

    // Index with no register behind it; writes there must be ignored.
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;

    localparam logic [COEF_BITS-1:0] COEF_MAX  = '1;
    localparam int                   DEPTH_ONE = 65536;
    localparam int                   DEPTH_MAX = 131071;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     cfg_we        = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr      = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata     = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [DW-1:0]            s_axis_tdata  = '0;   // sample_in
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [DW-1:0]            m_axis_tdata;         // sample_out

    int fail_count;
    int results_pending;
    int samples_in;
    int samples_out;
    int knee_hits;
    int clip_hits;

    int cycles        = 0;
    int settings_used = 0;
    int sent          = 0;
    int burst_left    = 0;
    int burst_kind    = 0;

    // Clock: 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    envelope_soft_knee_compressor_top #(
        .SAMPLE_BITS (SB)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    eskc_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata[SB-1:0]),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata[SB-1:0]),
        .fail_count  (fail_count),
        .pending     (results_pending),
        .samples_in  (samples_in),
        .samples_out (samples_out),
        .knee_hits   (knee_hits),
        .clip_hits   (clip_hits)
    );

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("tb_top: timed out after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Idle cycles before an item; every fourth window of items runs flat out.
    function automatic int idle_cycles(input int n);
        if ((n / 96) % 4 == 3)
        begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Random audio: bursts of one character so the envelope settles and moves.
    function automatic logic [SB-1:0] next_sample();
        int unsigned   mag;
        logic [SB-1:0] s;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(4, 40);
            burst_kind = $urandom_range(0, 5);
        end
        burst_left--;
        case (burst_kind)
            0:       mag = $urandom_range(0, 3);
            1:       mag = $urandom_range(0, 1 << 14);
            2:       mag = $urandom_range(1 << 17, 1 << 19);
            3:       mag = $urandom_range(1 << 21, 1 << 22);
            4:       mag = $urandom_range(1 << 22, (1 << (SB - 1)) - 1);
            default: mag = 0;
        endcase
        if (burst_kind == 5)
        begin
            s = SB'($urandom());
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            s = $urandom_range(0, 1) ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end
        else
        begin
            s = SB'(mag);
            if ($urandom_range(0, 1) == 1)
            begin
                s = -s;
            end
        end
        return s;
    endfunction

    // Writes all three registers, and the unused index when asked.
    task automatic write_settings(input logic [COEF_BITS-1:0] att,
                                  input logic [COEF_BITS-1:0] rel,
                                  input logic [CFG_DATA_BITS-1:0] depth_word,
                                  input bit touch_spare);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_ATTACK;
        cfg_wdata <= att;
        @(posedge clk);
        cfg_addr  <= REG_RELEASE;
        cfg_wdata <= rel;
        @(posedge clk);
        cfg_addr  <= REG_DEPTH;
        cfg_wdata <= depth_word;
        @(posedge clk);
        if (touch_spare)
        begin
            cfg_addr  <= REG_SPARE;
            cfg_wdata <= CFG_DATA_BITS'($urandom());
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_sample(input logic [SB-1:0] x);
        int gap;
        gap = idle_cycles(sent);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'(x);
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
    endtask

    // Stops offering and waits until every prediction has been retired.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Output side: random stalls, plus one long hold-off.
    initial
    begin
        int taken;
        int gap;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = (taken == HOLD_AT) ? HOLD_CYCLES : idle_cycles(taken);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            taken++;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int                       plain_set[]  = '{0, 8388607, -8388608, 1, -1};
        int                       knee_set[]   = '{262144, 262145, -262145, 262143,
                                                   8388607, -8388608, 0, 4194304};
        int                       clip_set[]   = '{8388607, -8388608, -1};
        int                       decay_set[]  = '{8388607, 0, 0, -8388607};
        logic [COEF_BITS-1:0]     att;
        logic [COEF_BITS-1:0]     rel;
        logic [CFG_DATA_BITS-1:0] depth_word;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no compression, slow follower.
        foreach (plain_set[i]) send_sample(SB'(plain_set[i]));
        drain();

        // Instant follower, deepest compression: around the knee and full scale.
        write_settings('0, '0, CFG_DATA_BITS'(DEPTH_MAX), 1'b1);
        foreach (knee_set[i]) send_sample(SB'(knee_set[i]));
        drain();

        // Frozen envelope with full make-up, applied to loud samples.
        write_settings(COEF_MAX, COEF_MAX, CFG_DATA_BITS'(DEPTH_MAX), 1'b0);
        foreach (clip_set[i]) send_sample(SB'(clip_set[i]));
        drain();

        // Fast attack, near-frozen release: the envelope holds over silence.
        write_settings('0, COEF_MAX, CFG_DATA_BITS'(DEPTH_ONE), 1'b0);
        foreach (decay_set[i]) send_sample(SB'(decay_set[i]));
        drain();

        // Random material under fixed and random settings.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: write_settings(ATTACK_RESET, RELEASE_RESET, CFG_DATA_BITS'(32768), 1'b0);
                1: write_settings('0, '0, CFG_DATA_BITS'(DEPTH_ONE), 1'b0);
                2: write_settings(COEF_MAX, COEF_MAX, CFG_DATA_BITS'(DEPTH_MAX), 1'b0);
                3: write_settings('0, COEF_MAX, CFG_DATA_BITS'(DEPTH_MAX), 1'b1);
                default:
                begin
                    att = $urandom_range(0, 1) ? COEF_BITS'($urandom())
                                               : COEF_MAX - COEF_BITS'($urandom_range(0, 1 << 17));
                    rel = $urandom_range(0, 1) ? COEF_BITS'($urandom())
                                               : COEF_MAX - COEF_BITS'($urandom_range(0, 1 << 14));
                    // Bits above the depth field are junk the block must drop.
                    depth_word = {7'($urandom()), 17'($urandom_range(0, DEPTH_MAX))};
                    write_settings(att, rel, depth_word, p[0]);
                end
            endcase
            repeat (PHASE_ITEMS) send_sample(next_sample());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb_top: %0d samples sent and %0d results checked over %0d register settings",
                 samples_in, samples_out, settings_used);
        $display("tb_top: %0d samples compressed above the knee, %0d clipped at full scale",
                 knee_hits, clip_hits);
        if (fail_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
